[hw/rtl/swec_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the sliding window event counter.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package swec_pkg;

  localparam int NUM_SLOTS_DEF        = 16;
  localparam int SLOT_COUNT_WIDTH_DEF = 24;
  localparam int COUNT_W              = 16;
  localparam int TOTAL_W              = 28;
  localparam int TALLY_W              = 32;
  localparam int QUEUE_DEPTH          = 4;

  typedef enum logic [1:0] {
    REQ_RECORD       = 2'd0,
    REQ_TICK         = 2'd1,
    REQ_CLEAR_WINDOW = 2'd2,
    REQ_CLEAR_STATS  = 2'd3
  } req_kind_t;

  // Classified operation handed from the front end to the execution side
  typedef struct packed {
    req_kind_t          kind;
    logic [COUNT_W-1:0] count;
  } op_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] window_total;
    logic               burst;
    logic [TALLY_W-1:0] total_events;
    logic [TALLY_W-1:0] total_bursts;
    logic [TALLY_W-1:0] total_slots_passed;
    logic [TOTAL_W-1:0] peak_total;
  } result_t;

endpackage

[hw/rtl/swec_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input items, decodes the request kind into an op_t and registers it.
// Depends on swec_pkg.
module swec_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [swec_pkg::COUNT_W-1:0] in_tdata,
  input  logic [1:0]                   in_tuser,
  output logic                         op_valid,
  input  logic                         op_ready,
  output swec_pkg::op_t                op_data
);

  logic          vld_r;
  swec_pkg::op_t op_r;
  swec_pkg::op_t op_nxt;

  assign in_tready = !vld_r || op_ready;
  assign op_valid  = vld_r;
  assign op_data   = op_r;

  // Drop the count on anything but a record so the back end never sees junk
  always_comb begin
    op_nxt.kind  = swec_pkg::req_kind_t'(in_tuser);
    op_nxt.count = (op_nxt.kind == swec_pkg::REQ_RECORD) ? in_tdata : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      vld_r <= 1'b1;
    end else if (op_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r <= op_nxt;
    end
  end

endmodule

[hw/rtl/swec_queue.sv]
`timescale 1ns / 1ps
// Short FIFO of decoded operations between front end and execution side.
// Depends on swec_pkg.
module swec_queue #(
  parameter int DEPTH = swec_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  swec_pkg::op_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output swec_pkg::op_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  swec_pkg::op_t   entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   fill_r;
  logic            push;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (fill_r != CW'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/swec_back.sv]
`timescale 1ns / 1ps
// Execution side: slot ring, window total, tallies, peak and the result register.
// Depends on swec_pkg.
module swec_back #(
  parameter int NUM_SLOTS        = swec_pkg::NUM_SLOTS_DEF,
  parameter int SLOT_COUNT_WIDTH = swec_pkg::SLOT_COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [swec_pkg::TOTAL_W-1:0] threshold,
  input  logic                         op_valid,
  output logic                         op_ready,
  input  swec_pkg::op_t                op_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output swec_pkg::result_t            res_data
);

  localparam int IW   = $clog2(NUM_SLOTS);
  localparam int SW   = SLOT_COUNT_WIDTH;
  localparam int TW   = SW + IW;
  localparam int SUMW = ((SW > swec_pkg::COUNT_W) ? SW : swec_pkg::COUNT_W) + 1;
  localparam int XW   = (TW > swec_pkg::TOTAL_W) ? TW : swec_pkg::TOTAL_W;
  localparam int LW   = swec_pkg::TALLY_W;
  localparam int PKW  = swec_pkg::TOTAL_W;

  // Slot store: the current slot lives in cur_r, the others in the memory.
  logic [SW-1:0]        mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [IW-1:0]        idx_r, idx_nxt, rd_addr;
  logic [SW-1:0]        cur_r, cur_nxt;
  logic [SW-1:0]        pre_r;               // old count of the slot after idx_r
  logic [TW-1:0]        total_r, total_nxt;
  logic [LW-1:0]        ev_r, ev_nxt, bu_r, bu_nxt, adv_r, adv_nxt;
  logic [PKW-1:0]       peak_r, peak_nxt;
  logic                 res_vld_r;
  swec_pkg::result_t    res_r, res_nxt;

  logic                 take;
  logic                 wr_en;
  logic [SUMW-1:0]      slot_sum;
  logic [SW-1:0]        cur_sat;
  logic [TW-1:0]        total_rec, total_tick;
  logic [PKW-1:0]       clip_old, clip_rec, clip_tick;
  logic [LW:0]          ev_sum;
  logic                 burst;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == IW'(NUM_SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [PKW-1:0] clip(input logic [TW-1:0] t);
    logic [XW-1:0] x;
    x = XW'(t);
    return (x > XW'({PKW{1'b1}})) ? {PKW{1'b1}} : x[PKW-1:0];
  endfunction

  function automatic logic [LW-1:0] sat_inc(input logic [LW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign op_ready  = !res_vld_r || res_ready;
  assign take      = op_valid && op_ready;
  assign res_valid = res_vld_r;
  assign res_data  = res_r;

  assign slot_sum   = SUMW'(cur_r) + SUMW'(op_data.count);
  assign cur_sat    = (|slot_sum[SUMW-1:SW]) ? {SW{1'b1}} : slot_sum[SW-1:0];
  assign total_rec  = total_r + TW'(cur_sat) - TW'(cur_r);
  assign total_tick = total_r - TW'(pre_r);
  assign clip_old   = clip(total_r);
  assign clip_rec   = clip(total_rec);
  assign clip_tick  = clip(total_tick);
  assign ev_sum     = (LW + 1)'(ev_r) + (LW + 1)'(op_data.count);

  always_comb begin
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    total_nxt = total_r;
    ev_nxt    = ev_r;
    bu_nxt    = bu_r;
    adv_nxt   = adv_r;
    peak_nxt  = peak_r;
    valid_nxt = valid_r;
    wr_en     = 1'b0;
    burst     = 1'b0;
    if (take) begin
      case (op_data.kind)
        swec_pkg::REQ_RECORD: begin
          // Peak is sampled before the events land
          if (clip_old > peak_r) begin
            peak_nxt = clip_old;
          end
          cur_nxt   = cur_sat;
          total_nxt = total_rec;
          ev_nxt    = ev_sum[LW] ? {LW{1'b1}} : ev_sum[LW-1:0];
          burst     = (threshold != '0) && (clip_rec > threshold);
          if (burst) begin
            bu_nxt = sat_inc(bu_r);
          end
        end
        swec_pkg::REQ_TICK: begin
          // Park the current slot in memory, open the next one empty
          wr_en            = 1'b1;
          valid_nxt[idx_r] = 1'b1;
          idx_nxt          = idx_inc(idx_r);
          cur_nxt          = '0;
          total_nxt        = total_tick;
          adv_nxt          = sat_inc(adv_r);
          if (clip_tick > peak_r) begin
            peak_nxt = clip_tick;
          end
        end
        swec_pkg::REQ_CLEAR_WINDOW: begin
          valid_nxt = '0;
          idx_nxt   = '0;
          cur_nxt   = '0;
          total_nxt = '0;
        end
        swec_pkg::REQ_CLEAR_STATS: begin
          ev_nxt   = '0;
          bu_nxt   = '0;
          adv_nxt  = '0;
          peak_nxt = '0;
        end
        default: begin
          idx_nxt = idx_r;
        end
      endcase
    end
  end

  // Prefetch address: the slot a following tick would subtract
  assign rd_addr = idx_inc(idx_nxt);

  always_comb begin
    res_nxt.window_total       = clip(total_nxt);
    res_nxt.burst              = burst;
    res_nxt.total_events       = ev_nxt;
    res_nxt.total_bursts       = bu_nxt;
    res_nxt.total_slots_passed = adv_nxt;
    res_nxt.peak_total         = peak_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      idx_r     <= '0;
      cur_r     <= '0;
      pre_r     <= '0;
      total_r   <= '0;
      ev_r      <= '0;
      bu_r      <= '0;
      adv_r     <= '0;
      peak_r    <= '0;
      res_vld_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
      cur_r   <= cur_nxt;
      total_r <= total_nxt;
      ev_r    <= ev_nxt;
      bu_r    <= bu_nxt;
      adv_r   <= adv_nxt;
      peak_r  <= peak_nxt;
      // Bypass the write in flight, treat never-written slots as zero
      if (wr_en && (idx_r == rd_addr)) begin
        pre_r <= cur_r;
      end else if (valid_nxt[rd_addr]) begin
        pre_r <= mem[rd_addr];
      end else begin
        pre_r <= '0;
      end
      if (take) begin
        res_vld_r <= 1'b1;
      end else if (res_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

[hw/rtl/sliding_window_event_counter.sv]
`timescale 1ns / 1ps
// Top level of the sliding window event counter: front end, op queue, execution side
// and the burst threshold register. Depends on swec_pkg, swec_front, swec_queue, swec_back.
//
//  Channel  Dir  Handshake               Payload
//  in_      in   in_tvalid / in_tready   tdata: event_count; tuser: req_type
//  out_     out  out_tvalid / out_tready tdata: window_total, total_events, total_bursts,
//                                        total_slots_passed, peak_total; tuser: burst
//  cfg_     in   cfg_valid / cfg_ready   cfg_data: burst_threshold
//
// One item per cycle sustained while out_ is not stalled. From input accept the item passes
// through the front register, the queue and the execution side with its result register.
// The rate is set by the slot update in swec_back, which reads the current slot from a
// register and the next slot from a prefetch register filled from the slot memory.
// Reset (rst_n low, synchronous) empties the window, the tallies and the threshold.
// A stall on out_ holds the result; the queue absorbs items until it fills, then
// in_tready drops. cfg_ready is always high.
module sliding_window_event_counter #(
  parameter int NUM_SLOTS        = swec_pkg::NUM_SLOTS_DEF,
  parameter int SLOT_COUNT_WIDTH = swec_pkg::SLOT_COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [15:0]   in_tdata,    // [15:0] event_count
  input  logic [1:0]    in_tuser,    // [1:0] req_type
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [151:0]  out_tdata,   // [27:0] window_total, [59:28] total_events,
                                     // [91:60] total_bursts, [123:92] total_slots_passed,
                                     // [151:124] peak_total
  output logic [0:0]    out_tuser,   // [0] burst
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [27:0]   cfg_data     // burst_threshold
);

  logic [swec_pkg::TOTAL_W-1:0] thr_r;
  logic                         f_valid, f_ready;
  swec_pkg::op_t                f_op;
  logic                         q_valid, q_ready;
  swec_pkg::op_t                q_op;
  swec_pkg::result_t            res;

  // Threshold takes writes at any time; the host must write only while idle, not enforced here
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // Decode and register the incoming item
  swec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .op_valid  (f_valid),
    .op_ready  (f_ready),
    .op_data   (f_op)
  );

  // Decouple decode from execution
  swec_queue #(
    .DEPTH (swec_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_op)
  );

  // Update the window and statistics, hold the result until taken
  swec_back #(
    .NUM_SLOTS        (NUM_SLOTS),
    .SLOT_COUNT_WIDTH (SLOT_COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (thr_r),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op_data   (q_op),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_data  (res)
  );

  assign out_tdata = {res.peak_total, res.total_slots_passed, res.total_bursts,
                      res.total_events, res.window_total};
  assign out_tuser = res.burst;

endmodule
